@@ rtl/core/wrhp_pkg.sv @@
// shared types and constants for the wav riff header parser
// holds the chunk tags, the status codes and the result record carried front to back
// no dependencies
package wrhp_pkg;

	localparam logic [31:0] MIN_FILE_BYTES = 32'd44;
	localparam logic [31:0] FMT_MIN_SIZE   = 32'd16;

	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;

	// result queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		PH_PREAMBLE,
		PH_HEADER,
		PH_BODY,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_SHORT,
		ST_NO_RIFF,
		ST_NO_WAVE,
		ST_NO_DATA
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] channels;
		logic [31:0] sample_rate;
		logic [15:0] bits_per_sample;
		logic [31:0] data_offset;
		logic [31:0] data_size;
	} result_t;

endpackage

@@ rtl/core/wrhp_front.sv @@
// front end of the wav riff header parser: takes one byte per word, walks the chunks
// and builds the result record on the last byte of a file
// depends on wrhp_pkg
module wrhp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        in_byte,
	input  logic              is_last,
	output logic              res_push,
	output wrhp_pkg::result_t res_data
);
	import wrhp_pkg::*;

	phase_t      phase_q, phase_nxt;
	logic [31:0] cnt_q, after;
	logic [31:0] tag_q, tag_nxt, size_q, size_nxt;
	logic [32:0] rem_q, rem_nxt;
	logic [2:0]  hidx_q, hidx_nxt;
	logic [4:0]  off_q, off_nxt;
	logic        riff_q, riff_nxt, wave_q, wave_nxt, found_q, found_nxt, fmt_q, fmt_nxt;
	logic [15:0] ch_q, ch_nxt, bits_q, bits_nxt;
	logic [31:0] rate_q, rate_nxt, offs_q, offs_nxt, dsize_q, dsize_nxt;

	logic [31:0] tag_sh, size_sh;
	logic [32:0] padded;
	logic        hdr_end, is_data, fmt_ok, in_tag_window;

	assign after   = (&cnt_q) ? cnt_q : cnt_q + 32'd1;
	assign tag_sh  = {tag_q[23:0], in_byte};
	assign size_sh = {in_byte, size_q[31:8]};

	// at the eighth header byte the tag is complete and the size takes its top byte
	assign hdr_end = (phase_q == PH_HEADER) && (hidx_q == 3'd7);
	assign is_data = (tag_q == TAG_DATA);
	assign fmt_ok  = (tag_q == TAG_FMT) && (size_sh >= FMT_MIN_SIZE);
	assign padded  = {1'b0, size_sh} + {32'd0, size_sh[0]};

	assign in_tag_window = (cnt_q < 32'd4) || ((cnt_q >= 32'd8) && (cnt_q < 32'd12));

	always_comb begin
		phase_nxt = phase_q;
		unique case (phase_q)
			PH_PREAMBLE: begin
				if (cnt_q == 32'd11) begin
					phase_nxt = PH_HEADER;
				end
			end
			PH_HEADER: begin
				if (hdr_end) begin
					if (is_data) begin
						phase_nxt = PH_DONE;
					end else if (padded != 33'd0) begin
						phase_nxt = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				if (rem_q == 33'd1) begin
					phase_nxt = PH_HEADER;
				end
			end
			PH_DONE: begin
				phase_nxt = PH_DONE;
			end
		endcase
	end

	always_comb begin
		tag_nxt   = tag_q;
		size_nxt  = size_q;
		rem_nxt   = rem_q;
		hidx_nxt  = hidx_q;
		off_nxt   = off_q;
		riff_nxt  = riff_q;
		wave_nxt  = wave_q;
		found_nxt = found_q;
		fmt_nxt   = fmt_q;
		ch_nxt    = ch_q;
		rate_nxt  = rate_q;
		bits_nxt  = bits_q;
		offs_nxt  = offs_q;
		dsize_nxt = dsize_q;
		unique case (phase_q)
			PH_PREAMBLE: begin
				if (in_tag_window) begin
					tag_nxt = tag_sh;
				end
				if (cnt_q == 32'd3) begin
					riff_nxt = (tag_sh == TAG_RIFF);
				end
				if (cnt_q == 32'd11) begin
					wave_nxt = (tag_sh == TAG_WAVE);
					rem_nxt  = 33'd0;
					hidx_nxt = 3'd0;
				end
			end
			PH_HEADER: begin
				if (hidx_q < 3'd4) begin
					tag_nxt = tag_sh;
				end else begin
					size_nxt = size_sh;
				end
				if (hdr_end) begin
					hidx_nxt = 3'd0;
					if (is_data) begin
						offs_nxt  = after;
						dsize_nxt = size_sh;
						found_nxt = 1'b1;
					end else begin
						// an accepted fmt chunk starts from cleared format fields
						if (fmt_ok) begin
							ch_nxt   = 16'd0;
							rate_nxt = 32'd0;
							bits_nxt = 16'd0;
						end
						fmt_nxt = fmt_ok;
						rem_nxt = padded;
						off_nxt = 5'd0;
					end
				end else begin
					hidx_nxt = hidx_q + 3'd1;
				end
			end
			PH_BODY: begin
				if (fmt_q) begin
					unique case (off_q)
						5'd2:    ch_nxt[7:0]      = in_byte;
						5'd3:    ch_nxt[15:8]     = in_byte;
						5'd4:    rate_nxt[7:0]    = in_byte;
						5'd5:    rate_nxt[15:8]   = in_byte;
						5'd6:    rate_nxt[23:16]  = in_byte;
						5'd7:    rate_nxt[31:24]  = in_byte;
						5'd14:   bits_nxt[7:0]    = in_byte;
						5'd15:   bits_nxt[15:8]   = in_byte;
						default: ;
					endcase
				end
				rem_nxt = rem_q - 33'd1;
				// body offset only matters below 16, so it parks there
				off_nxt = (off_q == 5'd16) ? off_q : off_q + 5'd1;
			end
			PH_DONE: ;
		endcase
	end

	always_comb begin
		res_data = '0;
		priority if (after < MIN_FILE_BYTES) begin
			res_data.status = ST_SHORT;
		end else if (!riff_nxt) begin
			res_data.status = ST_NO_RIFF;
		end else if (!wave_nxt) begin
			res_data.status = ST_NO_WAVE;
		end else if (!found_nxt) begin
			res_data.status = ST_NO_DATA;
		end else begin
			res_data.status          = ST_OK;
			res_data.channels        = ch_nxt;
			res_data.sample_rate     = rate_nxt;
			res_data.bits_per_sample = bits_nxt;
			res_data.data_offset     = offs_nxt;
			res_data.data_size       = dsize_nxt;
		end
	end

	assign res_push = take && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREAMBLE;
			cnt_q   <= '0;
			tag_q   <= '0;
			size_q  <= '0;
			rem_q   <= '0;
			hidx_q  <= '0;
			off_q   <= '0;
			riff_q  <= 1'b0;
			wave_q  <= 1'b0;
			found_q <= 1'b0;
			fmt_q   <= 1'b0;
			ch_q    <= '0;
			rate_q  <= '0;
			bits_q  <= '0;
			offs_q  <= '0;
			dsize_q <= '0;
		end else if (take && is_last) begin
			// end of file: next word starts a fresh file
			phase_q <= PH_PREAMBLE;
			cnt_q   <= '0;
			tag_q   <= '0;
			size_q  <= '0;
			rem_q   <= '0;
			hidx_q  <= '0;
			off_q   <= '0;
			riff_q  <= 1'b0;
			wave_q  <= 1'b0;
			found_q <= 1'b0;
			fmt_q   <= 1'b0;
			ch_q    <= '0;
			rate_q  <= '0;
			bits_q  <= '0;
			offs_q  <= '0;
			dsize_q <= '0;
		end else if (take) begin
			phase_q <= phase_nxt;
			cnt_q   <= after;
			tag_q   <= tag_nxt;
			size_q  <= size_nxt;
			rem_q   <= rem_nxt;
			hidx_q  <= hidx_nxt;
			off_q   <= off_nxt;
			riff_q  <= riff_nxt;
			wave_q  <= wave_nxt;
			found_q <= found_nxt;
			fmt_q   <= fmt_nxt;
			ch_q    <= ch_nxt;
			rate_q  <= rate_nxt;
			bits_q  <= bits_nxt;
			offs_q  <= offs_nxt;
			dsize_q <= dsize_nxt;
		end
	end

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take && is_last |=> (cnt_q == 32'd0) && (phase_q == PH_PREAMBLE) && !found_q)
		else $error("parser state not cleared after last word");

	a_done_found: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |-> found_q)
		else $error("done phase without a data chunk");

	a_body_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (rem_q != 33'd0))
		else $error("body phase with nothing left to skip");

	a_preamble_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PREAMBLE) |-> (cnt_q < 32'd12))
		else $error("preamble ran past the wave tag");

endmodule

@@ rtl/core/wrhp_queue.sv @@
// short result queue between the parser front end and the output stage
// depends on wrhp_pkg for the result record and queue depth
module wrhp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wrhp_pkg::result_t push_data,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output wrhp_pkg::result_t head
);
	import wrhp_pkg::*;

	result_t             slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push, do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/core/wrhp_back.sv @@
// output stage of the wav riff header parser: holds one result word for the receiver
// depends on wrhp_pkg for the result record
module wrhp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  wrhp_pkg::result_t q_head,
	output logic              pop,
	input  logic              out_ready,
	output logic              out_valid,
	output wrhp_pkg::result_t out_data
);
	import wrhp_pkg::*;

	logic    out_valid_q;
	result_t res_q;

	// refill whenever the register is empty or being drained
	assign pop       = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

@@ rtl/core/wav_riff_header_parser.sv @@
// top level of the wav riff header parser
// instantiates wrhp_front, wrhp_queue and wrhp_back; depends on wrhp_pkg
//
// usage:
//   input channel (in_valid/in_ready, in_byte, is_last) carries a wav file one byte
//   per word, in file order; is_last marks the final byte of each file.
//   output channel (out_valid/out_ready, status and the format fields) carries one
//   result word per file, produced by its last byte; status 0 means ok, and on any
//   failure all other fields read zero.
//   throughput: one byte per cycle while in_ready is high; the front end updates its
//   counters and shift registers once per byte, and back-to-back files are fine.
//   result path: the result word is written into the queue at the edge that takes the
//   last byte, then moves into an idle output register, which raises out_valid.
//   stall: a stalled receiver holds the output word; the two-entry result queue keeps
//   absorbing results, and in_ready drops only when the queue is full.
//   reset: arst_n clears the parser to the start of a file and empties the queue and
//   the output register; the next byte is taken as byte 0 of a new file.
module wav_riff_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] channels,
	output logic [31:0] sample_rate,
	output logic [15:0] bits_per_sample,
	output logic [31:0] data_offset,
	output logic [31:0] data_size
);
	import wrhp_pkg::*;

	logic    take, res_push, q_full, q_valid, q_pop;
	result_t res_data, q_head, out_data;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	wrhp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.in_byte  (in_byte),
		.is_last  (is_last),
		.res_push (res_push),
		.res_data (res_data)
	);

	wrhp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_data),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	wrhp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.pop       (q_pop),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	assign status          = out_data.status;
	assign channels        = out_data.channels;
	assign sample_rate     = out_data.sample_rate;
	assign bits_per_sample = out_data.bits_per_sample;
	assign data_offset     = out_data.data_offset;
	assign data_size       = out_data.data_size;

endmodule
